/* hw/rtl/srs2_pkg.sv */
// Package of the S2 record encoder: command type passed front to back,
// register indexes, sequencer phases and hex character lookup. No dependencies.
`default_nettype none

package srs2_pkg;

	localparam int QDEPTH = 2;
	localparam int PAD_W  = 8;

	localparam logic [1:0] REG_START_ADDRESS = 2'd0;
	localparam logic [1:0] REG_IMAGE_BYTES   = 2'd1;
	localparam logic [1:0] REG_ZERO_PAD      = 2'd2;
	localparam logic [1:0] REG_RAW_OUTPUT    = 2'd3;

	localparam logic [7:0] CHAR_S       = 8'h53;
	localparam logic [7:0] CHAR_TWO     = 8'h32;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_NONE    = 8'h00;

	localparam logic [1:0] COUNT_ONE = 2'd1;
	localparam logic [1:0] COUNT_TWO = 2'd2;

	typedef struct packed {
		logic [7:0]       data;
		logic             raw;
		logic             open;
		logic             close;
		logic             last;
		logic [7:0]       cnt;
		logic [23:0]      addr;
		logic [7:0]       chk;
		logic [PAD_W-1:0] pad;
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RAW,
		PH_HEAD,
		PH_CNT,
		PH_A2,
		PH_A1,
		PH_A0,
		PH_DATA,
		PH_PAD,
		PH_CHK,
		PH_NL
	} phase_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h37 + {4'd0, nib};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/srs2_front.sv */
// Front of the S2 record encoder: configuration registers, record tracking,
// checksum accumulation; issues one cmd_t per image byte. Uses srs2_pkg.
`default_nettype none

module srs2_front #(
	parameter int RECORD_BYTES    = 32,
	parameter int MAX_IMAGE_BYTES = 524288
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [23:0]         cfg_data,
	input  wire logic                push,
	input  wire logic [7:0]          data_byte,
	input  wire logic                q_full,
	output logic                     q_push,
	output srs2_pkg::cmd_t           q_wdata
);

	localparam int FW = $clog2(RECORD_BYTES + 1);
	localparam logic [FW-1:0] REC_W   = FW'(RECORD_BYTES);
	localparam logic [7:0]    REC_B   = 8'(RECORD_BYTES);
	localparam logic [7:0]    PAD_CNT = 8'(RECORD_BYTES + 4);
	localparam logic [20:0]   MAX_W   = 21'(MAX_IMAGE_BYTES);

	logic [23:0]   start_q;
	logic [19:0]   image_q;
	logic          zero_pad_q;
	logic          raw_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] len_q;
	logic [7:0]    sum_q;
	logic [23:0]   addr_q;
	logic [19:0]   rem_q;

	logic          cfg_we;
	logic [23:0]   start_n;
	logic [19:0]   image_n;
	logic [20:0]   rem_sat;
	logic          take;
	logic          open;
	logic [FW-1:0] len_cur;
	logic [FW-1:0] fill_n;
	logic [7:0]    cnt;
	logic [7:0]    hdr_sum;
	logic [7:0]    nsum;
	logic          close;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;

	always_comb begin
		start_n = start_q;
		image_n = image_q;
		if (cfg_we && cfg_index == srs2_pkg::REG_START_ADDRESS) begin
			start_n = cfg_data;
		end
		if (cfg_we && cfg_index == srs2_pkg::REG_IMAGE_BYTES) begin
			image_n = cfg_data[19:0];
		end
		rem_sat = ({1'b0, image_n} > MAX_W) ? MAX_W : {1'b0, image_n};
	end

	always_comb begin
		take    = push && !q_full && (rem_q != 20'd0);
		open    = (fill_q == '0);
		len_cur = open ? ((rem_q < 20'(RECORD_BYTES)) ? rem_q[FW-1:0] : REC_W) : len_q;
		fill_n  = fill_q + FW'(1);
		cnt     = zero_pad_q ? PAD_CNT : (8'(len_cur) + 8'd4);
		hdr_sum = cnt + addr_q[23:16] + addr_q[15:8] + addr_q[7:0];
		nsum    = (open ? hdr_sum : sum_q) + data_byte;
		close   = (fill_n >= len_cur);

		q_push        = take;
		q_wdata.data  = data_byte;
		q_wdata.raw   = raw_q;
		q_wdata.open  = open;
		q_wdata.close = close;
		q_wdata.last  = (raw_q || close) && (rem_q == 20'd1);
		q_wdata.cnt   = cnt;
		q_wdata.addr  = addr_q;
		q_wdata.chk   = ~nsum;
		q_wdata.pad   = zero_pad_q ? (REC_B - 8'(fill_n)) : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= 24'h020000;
			image_q    <= 20'd0;
			zero_pad_q <= 1'b1;
			raw_q      <= 1'b0;
			fill_q     <= '0;
			len_q      <= '0;
			sum_q      <= 8'd0;
			addr_q     <= 24'h020000;
			rem_q      <= 20'd0;
		end else if (cfg_we) begin
			start_q <= start_n;
			image_q <= image_n;
			case (cfg_index)
				srs2_pkg::REG_ZERO_PAD:   zero_pad_q <= cfg_data[0];
				srs2_pkg::REG_RAW_OUTPUT: raw_q      <= cfg_data[0];
				default: ;
			endcase
			fill_q <= '0;
			len_q  <= '0;
			sum_q  <= 8'd0;
			addr_q <= start_n;
			rem_q  <= rem_sat[19:0];
		end else if (take) begin
			rem_q <= rem_q - 20'd1;
			if (!raw_q) begin
				if (close) begin
					addr_q <= addr_q + 24'(len_cur);
					fill_q <= '0;
					len_q  <= '0;
					sum_q  <= 8'd0;
				end else begin
					fill_q <= fill_n;
					len_q  <= len_cur;
					sum_q  <= nsum;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (fill_q == '0) && (sum_q == 8'd0))
		else $error("record state not cleared after register write");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && !raw_q) |-> (fill_n <= len_cur) || (len_cur == '0))
		else $error("record fill ran past record length");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) |-> (len_q != '0) && (fill_q < len_q))
		else $error("open record has inconsistent fill");

endmodule

`default_nettype wire

/* hw/rtl/srs2_queue.sv */
// Short command queue between front and back of the S2 record encoder.
// Holds srs2_pkg::cmd_t entries in registers.
`default_nettype none

module srs2_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire srs2_pkg::cmd_t wdata,
	input  wire logic           rd_en,
	output srs2_pkg::cmd_t      rdata,
	output logic                q_full,
	output logic                q_empty
);

	localparam int PW = (srs2_pkg::QDEPTH > 1) ? $clog2(srs2_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(srs2_pkg::QDEPTH + 1);

	srs2_pkg::cmd_t mem_q [srs2_pkg::QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign q_full  = (count_q == CW'(srs2_pkg::QDEPTH));
	assign q_empty = (count_q == '0);
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(srs2_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(srs2_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/srs2_back.sv */
// Back of the S2 record encoder: phase sequencer that expands each cmd_t into
// character results, plus the output register. Uses srs2_pkg.
`default_nettype none

module srs2_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire srs2_pkg::cmd_t head,
	input  wire logic           q_empty,
	output logic                q_pop,
	input  wire logic           pop,
	output logic                empty,
	output logic [7:0]          first_char,
	output logic [7:0]          second_char,
	output logic [1:0]          char_count,
	output logic                run_last,
	output logic                image_end
);

	srs2_pkg::phase_t  phase_q;
	srs2_pkg::phase_t  eff;
	srs2_pkg::phase_t  nxt;
	logic [srs2_pkg::PAD_W-1:0] pad_left_q;
	logic              out_v_q;
	logic [7:0]        c1_q;
	logic [7:0]        c2_q;
	logic [1:0]        cc_q;
	logic              rl_q;
	logic              ie_q;

	logic              pop_ok;
	logic              adv;
	logic [7:0]        hex_v;
	logic [7:0]        c1;
	logic [7:0]        c2;
	logic [1:0]        cc;
	logic              rl;
	logic              ie;

	assign pop_ok = pop && out_v_q;
	assign adv    = !q_empty && (!out_v_q || pop_ok);

	always_comb begin
		if (phase_q == srs2_pkg::PH_IDLE) begin
			eff = head.raw ? srs2_pkg::PH_RAW :
				(head.open ? srs2_pkg::PH_HEAD : srs2_pkg::PH_DATA);
		end else begin
			eff = phase_q;
		end

		hex_v = head.data;
		c1    = srs2_pkg::CHAR_NONE;
		c2    = srs2_pkg::CHAR_NONE;
		cc    = srs2_pkg::COUNT_TWO;
		rl    = 1'b0;
		ie    = 1'b0;
		nxt   = srs2_pkg::PH_IDLE;

		case (eff)
			srs2_pkg::PH_RAW: begin
				c1  = head.data;
				cc  = srs2_pkg::COUNT_ONE;
				rl  = 1'b1;
				ie  = head.last;
			end
			srs2_pkg::PH_HEAD: begin
				c1  = srs2_pkg::CHAR_S;
				c2  = srs2_pkg::CHAR_TWO;
				nxt = srs2_pkg::PH_CNT;
			end
			srs2_pkg::PH_CNT: begin
				hex_v = head.cnt;
				nxt   = srs2_pkg::PH_A2;
			end
			srs2_pkg::PH_A2: begin
				hex_v = head.addr[23:16];
				nxt   = srs2_pkg::PH_A1;
			end
			srs2_pkg::PH_A1: begin
				hex_v = head.addr[15:8];
				nxt   = srs2_pkg::PH_A0;
			end
			srs2_pkg::PH_A0: begin
				hex_v = head.addr[7:0];
				nxt   = srs2_pkg::PH_DATA;
			end
			srs2_pkg::PH_DATA: begin
				hex_v = head.data;
				if (!head.close) begin
					rl  = 1'b1;
					nxt = srs2_pkg::PH_IDLE;
				end else if (head.pad != '0) begin
					nxt = srs2_pkg::PH_PAD;
				end else begin
					nxt = srs2_pkg::PH_CHK;
				end
			end
			srs2_pkg::PH_PAD: begin
				hex_v = 8'd0;
				nxt   = (pad_left_q == 8'd1) ? srs2_pkg::PH_CHK : srs2_pkg::PH_PAD;
			end
			srs2_pkg::PH_CHK: begin
				hex_v = head.chk;
				nxt   = srs2_pkg::PH_NL;
			end
			srs2_pkg::PH_NL: begin
				c1  = srs2_pkg::CHAR_NEWLINE;
				cc  = srs2_pkg::COUNT_ONE;
				rl  = 1'b1;
				ie  = head.last;
			end
			default: begin
				nxt = srs2_pkg::PH_IDLE;
			end
		endcase

		if (eff == srs2_pkg::PH_CNT || eff == srs2_pkg::PH_A2 || eff == srs2_pkg::PH_A1 ||
			eff == srs2_pkg::PH_A0 || eff == srs2_pkg::PH_DATA || eff == srs2_pkg::PH_PAD ||
			eff == srs2_pkg::PH_CHK) begin
			c1 = srs2_pkg::hex_char(hex_v[7:4]);
			c2 = srs2_pkg::hex_char(hex_v[3:0]);
		end

		q_pop = adv && rl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= srs2_pkg::PH_IDLE;
			pad_left_q <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (adv) begin
				phase_q <= nxt;
				out_v_q <= 1'b1;
				if (eff == srs2_pkg::PH_DATA) begin
					pad_left_q <= head.pad;
				end else if (eff == srs2_pkg::PH_PAD) begin
					pad_left_q <= pad_left_q - 8'd1;
				end
			end else if (pop_ok) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c1_q <= c1;
			c2_q <= c2;
			cc_q <= cc;
			rl_q <= rl;
			ie_q <= ie;
		end
	end

	assign empty       = !out_v_q;
	assign first_char  = c1_q;
	assign second_char = c2_q;
	assign char_count  = cc_q;
	assign run_last    = rl_q;
	assign image_end   = ie_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> adv)
		else $error("command dropped without its last result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == srs2_pkg::PH_PAD) |-> (pad_left_q != '0))
		else $error("padding phase with no padding left");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != srs2_pkg::PH_IDLE) |-> !q_empty)
		else $error("sequencer busy without a command");

endmodule

`default_nettype wire

/* hw/rtl/srecord_s2_encoder_top.sv */
// Top level of the Motorola S2 record encoder: front, command queue, back.
// Depends on srs2_pkg, srs2_front, srs2_queue, srs2_back.
//
//   channel   handshake            payload
//   input     push / full          data_byte
//   result    pop / empty          first_char, second_char, char_count, run_last, image_end
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The back sequencer emits one result per cycle while the queue holds a command and the
// result side pops; a byte gives 1 result in raw mode or mid-record, 5 more when it opens
// a record, and padding count plus 2 more when it closes one.
// The front takes a byte per cycle while the two-entry command queue has room.
// Reset loads the register defaults at once; no clearing pass. Config writes are
// always ready. A stalled pop holds the result register and backs up into the queue.
`default_nettype none

module srecord_s2_encoder_top #(
	parameter int RECORD_BYTES    = 32,
	parameter int MAX_IMAGE_BYTES = 524288
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       first_char,
	output logic [7:0]       second_char,
	output logic [1:0]       char_count,
	output logic             run_last,
	output logic             image_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	srs2_pkg::cmd_t q_wdata;
	srs2_pkg::cmd_t q_rdata;
	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;

	srs2_front #(
		.RECORD_BYTES    (RECORD_BYTES),
		.MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.data_byte (data_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	srs2_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wdata   (q_wdata),
		.rd_en   (q_pop),
		.rdata   (q_rdata),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	srs2_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_rdata),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.first_char  (first_char),
		.second_char (second_char),
		.char_count  (char_count),
		.run_last    (run_last),
		.image_end   (image_end)
	);

	assign full = q_full;

endmodule

`default_nettype wire

/* tb/sv/srecord_monitor.sv */
// Checker for the S2 record encoder: watches the byte, result and register channels,
// predicts the character stream of each accepted byte and compares it in order.
// Depends on srs2_pkg for register indexes, character codes and counts.
module srecord_monitor import srs2_pkg::*; #(
	parameter int REC_BYTES  = 32,
	parameter int IMAGE_CAP  = 524288,
	parameter int PRINT_CAP  = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  first_char,
	input  logic [7:0]  second_char,
	input  logic [1:0]  char_count,
	input  logic        run_last,
	input  logic        image_end,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          pending,
	output int          fail_count
);

	typedef struct packed {
		logic [7:0] first_char;
		logic [7:0] second_char;
		logic [1:0] char_count;
		logic       run_last;
		logic       image_end;
	} char_pair_t;

	char_pair_t expected_chars[$];
	char_pair_t burst[$];

	logic [23:0] base_address;
	logic [19:0] img_bytes;
	logic        pad_on;
	logic        raw_mode;

	int          fill;
	int          rec_len;
	logic [7:0]  csum;
	logic [23:0] rec_addr;
	int          left;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] c;
		if (nib > 4'd9) begin
			c = 8'h41 + 8'(nib - 4'd10);
		end else begin
			c = CHAR_ZERO + 8'(nib);
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_count < PRINT_CAP) begin
			$display("srecord mismatch at %0t: %s", $time, what);
		end
		fail_count++;
	endtask

	task automatic restart_image();
		fill = 0;
		rec_len = 0;
		csum = 8'd0;
		rec_addr = base_address;
		left = (int'(img_bytes) > IMAGE_CAP) ? IMAGE_CAP : int'(img_bytes);
	endtask

	task automatic add_chars(input logic [7:0] c1, input logic [7:0] c2, input logic [1:0] cnt);
		char_pair_t r;
		r = '{first_char: c1, second_char: c2, char_count: cnt, run_last: 1'b0,
			image_end: 1'b0};
		burst.push_back(r);
	endtask

	task automatic add_hex(input logic [7:0] v);
		add_chars(hex_digit(v[7:4]), hex_digit(v[3:0]), COUNT_TWO);
	endtask

	task automatic encode_byte(input logic [7:0] b);
		logic [7:0] cnt;
		logic       closes_image;
		char_pair_t tail;
		burst.delete();
		if (left == 0) return;
		closes_image = 1'b0;
		if (raw_mode) begin
			add_chars(b, CHAR_NONE, COUNT_ONE);
			left--;
			closes_image = (left == 0);
		end else begin
			if (fill == 0) begin
				rec_len = (left < REC_BYTES) ? left : REC_BYTES;
				cnt = 8'((pad_on ? REC_BYTES : rec_len) + 4);
				add_chars(CHAR_S, CHAR_TWO, COUNT_TWO);
				add_hex(cnt);
				add_hex(rec_addr[23:16]);
				add_hex(rec_addr[15:8]);
				add_hex(rec_addr[7:0]);
				csum = cnt + rec_addr[23:16] + rec_addr[15:8] + rec_addr[7:0];
			end
			add_hex(b);
			csum = csum + b;
			fill++;
			left--;
			if (fill >= rec_len) begin
				if (pad_on) begin
					for (int i = fill; i < REC_BYTES; i++) begin
						add_chars(CHAR_ZERO, CHAR_ZERO, COUNT_TWO);
					end
				end
				add_hex(8'hFF - csum);
				add_chars(CHAR_NEWLINE, CHAR_NONE, COUNT_ONE);
				rec_addr = rec_addr + 24'(rec_len);
				fill = 0;
				rec_len = 0;
				csum = 8'd0;
				closes_image = (left == 0);
			end
		end
		tail = burst.pop_back();
		tail.run_last = 1'b1;
		tail.image_end = closes_image;
		burst.push_back(tail);
		foreach (burst[i]) begin
			expected_chars.push_back(burst[i]);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %02h, want %02h", name, got, want));
		end
	endtask

	task automatic check_result();
		char_pair_t want;
		if (expected_chars.size() == 0) begin
			report_mismatch($sformatf("result %02h %02h with nothing expected",
				first_char, second_char));
		end else begin
			want = expected_chars.pop_front();
			check_field("first_char", first_char, want.first_char);
			check_field("second_char", second_char, want.second_char);
			check_field("char_count", 8'(char_count), 8'(want.char_count));
			check_field("run_last", 8'(run_last), 8'(want.run_last));
			check_field("image_end", 8'(image_end), 8'(want.image_end));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address = 24'h020000;
			img_bytes = 20'd0;
			pad_on = 1'b1;
			raw_mode = 1'b0;
			restart_image();
			expected_chars.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (pop && !empty) begin
				check_result();
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_START_ADDRESS: base_address = cfg_data;
					REG_IMAGE_BYTES:   img_bytes = cfg_data[19:0];
					REG_ZERO_PAD:      pad_on = cfg_data[0];
					REG_RAW_OUTPUT:    raw_mode = cfg_data[0];
					default: ;
				endcase
				restart_image();
			end
			if (push && !full) begin
				encode_byte(data_byte);
			end
			pending = expected_chars.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
// Testbench top of the S2 record encoder: clock, reset, byte and register stimulus,
// random result drain and verdict. Depends on srs2_pkg, srecord_s2_encoder_top and
// srecord_monitor, which does all prediction and comparison.
module tb;
	import srs2_pkg::*;

	localparam int IMAGE_CAP     = 524288;
	localparam int ITEM_TARGET   = 460;
	localparam int CALM_ITEMS    = 60;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        push        = 1'b0;
	logic [7:0]  data_byte   = 8'd0;
	logic        pop         = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic [1:0]  cfg_index   = 2'd0;
	logic [23:0] cfg_data    = 24'd0;
	logic        full;
	logic        empty;
	logic [7:0]  first_char;
	logic [7:0]  second_char;
	logic [1:0]  char_count;
	logic        run_last;
	logic        image_end;
	logic        cfg_ready;
	int          pending;
	int          fail_count;

	bit          calm      = 1'b0;
	bit          hold_req  = 1'b0;
	bit          hold_done = 1'b0;

	logic [19:0] cur_len = 20'd0;

	srecord_s2_encoder_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.empty       (empty),
		.pop         (pop),
		.first_char  (first_char),
		.second_char (second_char),
		.char_count  (char_count),
		.run_last    (run_last),
		.image_end   (image_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	srecord_monitor #(
		.REC_BYTES (32),
		.IMAGE_CAP (IMAGE_CAP)
	) i_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.empty       (empty),
		.pop         (pop),
		.first_char  (first_char),
		.second_char (second_char),
		.char_count  (char_count),
		.run_last    (run_last),
		.image_end   (image_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_byte(input logic [7:0] b);
		bit took;
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		do begin
			@(negedge clk);
			took = !full;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic settle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input logic [23:0] addr, input logic [19:0] nbytes,
			input logic pad, input logic raw, input logic [3:0] mask);
		logic [1:0]  idx;
		logic [23:0] d;
		bit          took;
		for (int r = 0; r < 4; r++) begin
			idx = 2'(r);
			case (idx)
				REG_START_ADDRESS: d = addr;
				REG_IMAGE_BYTES:   d = {4'd0, nbytes};
				REG_ZERO_PAD:      d = {23'd0, pad};
				default:           d = {23'd0, raw};
			endcase
			if (mask[idx]) begin
				if (idx == REG_IMAGE_BYTES) cur_len = nbytes;
				cfg_valid <= 1'b1;
				cfg_index <= idx;
				cfg_data <= d;
				do begin
					@(negedge clk);
					took = cfg_ready;
					@(posedge clk);
				end while (!took);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : result_sink
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (calm) begin
				pop <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("[srecord_s2_encoder_top] ERROR");
		$finish;
	end

	initial begin : stimulus
		int          items_sent;
		int          img_len;
		int          n_send;
		int          k;
		logic [23:0] addr;
		logic [19:0] nbytes;
		logic        pad;
		logic        raw;
		logic [3:0]  mask;
		logic [7:0]  b;
		items_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty image after reset: everything is dropped
		send_byte(8'h00);
		send_byte(8'hFF);
		settle();

		// one-byte record padded to full length, then a byte past the image
		apply_config(24'hFFFFFF, 20'd1, 1'b1, 1'b0, 4'hF);
		send_byte(8'hA5);
		send_byte(8'h3C);
		items_sent += 1;
		settle();

		apply_config(24'hFFFFFE, 20'd3, 1'b0, 1'b0, 4'hF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		items_sent += 3;
		settle();

		apply_config(24'h000000, 20'd4, 1'b1, 1'b1, 4'hF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h0F);
		send_byte(8'hF0);
		send_byte(8'h55);
		items_sent += 4;
		settle();

		// oversized image saturates; restart mid-image
		apply_config(24'h000000, 20'hFFFFF, 1'b0, 1'b1, 4'hF);
		send_byte(8'h7E);
		send_byte(8'h81);
		send_byte(8'hC3);
		items_sent += 3;
		settle();

		apply_config(24'h123456, 20'hFFFFF, 1'b1, 1'b0, 4'hF);
		send_byte(8'h01);
		send_byte(8'hFE);
		send_byte(8'h7F);
		items_sent += 3;
		settle();

		// hold the result side off long enough to back up into the input
		apply_config(24'($urandom), 20'd64, 1'b1, 1'b0, 4'hF);
		hold_req = 1'b1;
		for (int i = 0; i < 64; i++) begin
			send_byte(8'($urandom_range(0, 255)));
		end
		items_sent += 64;
		settle();

		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 3))
				0: addr = 24'h000000;
				1: addr = 24'hFFFFFF;
				2: addr = 24'hFFFFFF - 24'($urandom_range(0, 64));
				default: addr = 24'($urandom);
			endcase
			k = $urandom_range(0, 15);
			if (k == 0) begin
				nbytes = 20'd0;
			end else if (k == 1) begin
				nbytes = 20'($urandom_range(IMAGE_CAP + 1, 1048575));
			end else if (k == 2) begin
				nbytes = 20'(32 * $urandom_range(1, 2) + $urandom_range(0, 1));
			end else begin
				nbytes = 20'($urandom_range(1, 70));
			end
			pad = 1'($urandom_range(0, 1));
			raw = ($urandom_range(0, 4) == 0);
			mask = 4'($urandom_range(0, 15));
			mask[REG_IMAGE_BYTES] = 1'b1;
			apply_config(addr, nbytes, pad, raw, mask);

			img_len = (int'(cur_len) > IMAGE_CAP) ? IMAGE_CAP : int'(cur_len);
			n_send = (img_len > 90) ? $urandom_range(1, 90) : img_len;
			if ($urandom_range(0, 7) == 0) n_send = $urandom_range(0, n_send);
			for (int i = 0; i < n_send; i++) begin
				b = ($urandom_range(0, 9) == 0) ? {8{1'($urandom_range(0, 1))}}
					: 8'($urandom_range(0, 255));
				send_byte(b);
				items_sent++;
				if (!calm && $urandom_range(0, 59) == 0) drain_results();
			end
			if (n_send == img_len && $urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			end
			if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
			settle();
		end

		if (fail_count == 0) begin
			$display("[srecord_s2_encoder_top] OK");
		end else begin
			$display("[srecord_s2_encoder_top] ERROR");
		end
		$finish;
	end

endmodule

/* srecord_s2_encoder_top.f */
hw/rtl/srs2_pkg.sv
hw/rtl/srs2_front.sv
hw/rtl/srs2_queue.sv
hw/rtl/srs2_back.sv
hw/rtl/srecord_s2_encoder_top.sv
tb/sv/srecord_monitor.sv
tb/sv/tb.sv
